// File: rtl/core/bmm_pkg.sv
package bmm_pkg;

  // Field widths of one input beat and one result beat.
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned TARGET_W = 2;
  localparam int unsigned MADDR_W  = 19;

  // Window and bank geometry.
  localparam int unsigned WINDOWS   = 8;
  localparam int unsigned WIN_W     = 3;
  localparam int unsigned OFFSET_W  = 13;
  localparam int unsigned BANK_W    = 6;
  localparam int unsigned KANJI_OFF_W  = 11;
  localparam int unsigned KANJI_PAGE_W = 7;

  // Special bank numbers.
  localparam logic [BANK_W-1:0] BANK_SPECIAL = 6'h39;
  localparam logic [BANK_W-1:0] BANK_IPL_LO  = 6'h34;
  localparam logic [BANK_W-1:0] BANK_IPL_HI  = 6'h37;

  // Bit positions in the kanji bank and reset-control bytes.
  localparam int unsigned KANJI_ROM_BIT  = 7;
  localparam int unsigned RST_IDENT_BIT  = 1;
  localparam int unsigned RST_IPL_BIT    = 3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_MEM_READ    = 3'd0,
    ACT_MEM_WRITE   = 3'd1,
    ACT_INDEX_WRITE = 3'd2,
    ACT_INDEX_READ  = 3'd3,
    ACT_BANK_READ   = 3'd4,
    ACT_BANK_WRITE  = 3'd5,
    ACT_KANJI_WRITE = 3'd6,
    ACT_RESET_CTRL  = 3'd7
  } action_t;

  typedef enum logic [TARGET_W-1:0] {
    TGT_NONE  = 2'd0,
    TGT_MAIN  = 2'd1,
    TGT_KANJI = 2'd2,
    TGT_PCG   = 2'd3
  } target_t;

  typedef struct packed {
    action_t             action;
    logic [ADDR_W-1:0]   cpu_address;
    logic [DATA_W-1:0]   write_data;
  } item_t;

  typedef struct packed {
    target_t             target;
    logic [MADDR_W-1:0]  mem_address;
    logic                mem_write_enable;
    logic [DATA_W-1:0]   mem_write_data;
    logic [DATA_W-1:0]   reg_data;
    logic                cpu_reset_pulse;
  } result_t;

  // Mapper state seen by the translation logic.
  typedef struct packed {
    logic [BANK_W-1:0]   bank;
    logic [WIN_W-1:0]    bank_index;
    logic [DATA_W-1:0]   kanji_sel;
    logic [DATA_W-1:0]   prev_lines;
  } map_view_t;

  // Bank set loaded at power-up and on the IPL reset edge.
  function automatic logic [BANK_W-1:0] ipl_bank(input logic [WIN_W-1:0] win);
    logic [BANK_W-1:0] b;
    if (win[WIN_W-1]) begin
      b = {{(BANK_W-WIN_W){1'b0}}, win};
    end else begin
      b = BANK_IPL_LO + {{(BANK_W-WIN_W){1'b0}}, win};
    end
    return b;
  endfunction

endpackage

// File: rtl/core/bmm_if.sv
interface bmm_in_if;
  logic                         valid;
  logic                         ready;
  logic [bmm_pkg::ACTION_W-1:0] action;
  logic [bmm_pkg::ADDR_W-1:0]   cpu_address;
  logic [bmm_pkg::DATA_W-1:0]   write_data;

  modport source (output valid, output action, output cpu_address, output write_data,
                  input ready);
  modport sink   (input valid, input action, input cpu_address, input write_data,
                  output ready);
endinterface

interface bmm_out_if;
  logic                         valid;
  logic                         ready;
  logic [bmm_pkg::TARGET_W-1:0] target;
  logic [bmm_pkg::MADDR_W-1:0]  mem_address;
  logic                         mem_write_enable;
  logic [bmm_pkg::DATA_W-1:0]   mem_write_data;
  logic [bmm_pkg::DATA_W-1:0]   reg_data;
  logic                         cpu_reset_pulse;

  modport source (output valid, output target, output mem_address,
                  output mem_write_enable, output mem_write_data, output reg_data,
                  output cpu_reset_pulse, input ready);
  modport sink   (input valid, input target, input mem_address,
                  input mem_write_enable, input mem_write_data, input reg_data,
                  input cpu_reset_pulse, output ready);
endinterface

// File: rtl/core/bmm_translate.sv
module bmm_translate (
  input  bmm_pkg::item_t     item,
  input  bmm_pkg::map_view_t view,
  output bmm_pkg::result_t   result
);
  import bmm_pkg::*;

  logic [OFFSET_W-1:0] offset;
  logic                is_write;
  logic                ipl_bank_hit;

  assign offset       = item.cpu_address[OFFSET_W-1:0];
  assign is_write     = (item.action == ACT_MEM_WRITE);
  assign ipl_bank_hit = (view.bank >= BANK_IPL_LO) && (view.bank <= BANK_IPL_HI);

  // Address translation, register reads and the CPU reset pulse for one beat.
  always_comb begin
    result = '0;
    unique case (item.action)
      ACT_MEM_READ, ACT_MEM_WRITE: begin
        if (view.bank == BANK_SPECIAL) begin
          if (view.kanji_sel[KANJI_ROM_BIT]) begin
            // Kanji ROM is read-only; a write there is dropped.
            if (!is_write) begin
              result.target      = TGT_KANJI;
              result.mem_address = {{(MADDR_W-KANJI_PAGE_W-KANJI_OFF_W){1'b0}},
                                    view.kanji_sel[KANJI_PAGE_W-1:0],
                                    offset[KANJI_OFF_W-1:0]};
            end
          end else begin
            result.target           = TGT_PCG;
            result.mem_address      = {{(MADDR_W-OFFSET_W){1'b0}}, offset};
            result.mem_write_enable = is_write;
          end
        end else if (!(is_write && ipl_bank_hit)) begin
          result.target           = TGT_MAIN;
          result.mem_address      = {view.bank, offset};
          result.mem_write_enable = is_write;
        end
        if (result.mem_write_enable) begin
          result.mem_write_data = item.write_data;
        end
      end
      ACT_INDEX_READ: begin
        result.reg_data = {{(DATA_W-WIN_W){1'b0}}, view.bank_index};
      end
      ACT_BANK_READ: begin
        result.reg_data = {{(DATA_W-BANK_W){1'b0}}, view.bank};
      end
      ACT_RESET_CTRL: begin
        result.cpu_reset_pulse = !view.prev_lines[RST_IDENT_BIT] &&
                                 item.write_data[RST_IDENT_BIT];
      end
      ACT_INDEX_WRITE, ACT_BANK_WRITE, ACT_KANJI_WRITE: begin
        result = '0;
      end
      default: begin
        result = '0;
      end
    endcase
  end

endmodule

// File: rtl/core/banked_memory_mapper_core.sv
// Banked memory mapper. Each input beat is one CPU-side action: a memory read or
// write to translate, or an access to the bank index, bank, kanji bank or reset
// control registers. Every beat yields exactly one result beat, in order. The
// block takes one beat per clock cycle unless the output stalls. A beat sits in
// the input register, where the translation and the read of the eight-entry
// window bank register file run into the result register, which presents its
// result beat. A stalled output holds the input register and then the input.
// State changes (bank writes, index moves, reset-edge bank reloads) take effect
// for the very next beat. Reset is synchronous on rst and restores the IPL bank
// set, index 0, kanji bank 0 and reset lines 0.
module banked_memory_mapper_core (
  input  logic     clk,
  input  logic     rst,
  bmm_in_if.sink   in_ch,
  bmm_out_if.source out_ch
);
  import bmm_pkg::*;

  // Input register.
  logic    s1_valid;
  item_t   s1_item;

  // Result register.
  logic    out_valid;
  result_t out_data;

  // Mapper state.
  logic [BANK_W-1:0] window_banks [WINDOWS];
  logic [WIN_W-1:0]  bank_index;
  logic [DATA_W-1:0] kanji_sel;
  logic [DATA_W-1:0] rst_ctrl_prev;

  logic              out_free;
  logic              s1_fire;
  logic [WIN_W-1:0]  rd_index;
  map_view_t         view;
  result_t           result;
  logic              ident_edge;
  logic              ipl_edge;

  // Handshake: the input stage moves on whenever the result register frees up.
  assign out_free    = !out_valid || out_ch.ready;
  assign s1_fire     = s1_valid && out_free;
  assign in_ch.ready = !s1_valid || out_free;

  // One read of the bank file: the addressed window or the index register.
  assign rd_index = ((s1_item.action == ACT_MEM_READ) || (s1_item.action == ACT_MEM_WRITE))
                    ? s1_item.cpu_address[ADDR_W-1 -: WIN_W] : bank_index;

  assign view.bank       = window_banks[rd_index];
  assign view.bank_index = bank_index;
  assign view.kanji_sel  = kanji_sel;
  assign view.prev_lines = rst_ctrl_prev;

  bmm_translate u_translate (
    .item   (s1_item),
    .view   (view),
    .result (result)
  );

  assign ident_edge = !rst_ctrl_prev[RST_IDENT_BIT] && s1_item.write_data[RST_IDENT_BIT];
  assign ipl_edge   = !rst_ctrl_prev[RST_IPL_BIT] && s1_item.write_data[RST_IPL_BIT];

  // Input register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_item.action      <= action_t'(in_ch.action);
      s1_item.cpu_address <= in_ch.cpu_address;
      s1_item.write_data  <= in_ch.write_data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data <= result;
    end
  end

  // State updates, applied when the beat leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOWS; i++) begin
        window_banks[i] <= ipl_bank(WIN_W'(i));
      end
      bank_index    <= '0;
      kanji_sel     <= '0;
      rst_ctrl_prev <= '0;
    end else if (s1_fire) begin
      unique case (s1_item.action)
        ACT_INDEX_WRITE: begin
          bank_index <= s1_item.write_data[WIN_W-1:0];
        end
        ACT_BANK_READ: begin
          bank_index <= bank_index + WIN_W'(1);
        end
        ACT_BANK_WRITE: begin
          window_banks[bank_index] <= s1_item.write_data[BANK_W-1:0];
          bank_index               <= bank_index + WIN_W'(1);
        end
        ACT_KANJI_WRITE: begin
          kanji_sel <= s1_item.write_data;
        end
        ACT_RESET_CTRL: begin
          // The IPL set wins when both edges arrive in one beat.
          priority if (ipl_edge) begin
            for (int i = 0; i < WINDOWS; i++) begin
              window_banks[i] <= ipl_bank(WIN_W'(i));
            end
          end else if (ident_edge) begin
            for (int i = 0; i < WINDOWS; i++) begin
              window_banks[i] <= BANK_W'(i);
            end
          end else begin
            bank_index <= bank_index;
          end
          rst_ctrl_prev <= s1_item.write_data;
        end
        ACT_MEM_READ, ACT_MEM_WRITE, ACT_INDEX_READ: begin
          bank_index <= bank_index;
        end
        default: begin
          bank_index <= bank_index;
        end
      endcase
    end
  end

  // Output beat.
  assign out_ch.valid            = out_valid;
  assign out_ch.target           = out_data.target;
  assign out_ch.mem_address      = out_data.mem_address;
  assign out_ch.mem_write_enable = out_data.mem_write_enable;
  assign out_ch.mem_write_data   = out_data.mem_write_data;
  assign out_ch.reg_data         = out_data.reg_data;
  assign out_ch.cpu_reset_pulse  = out_data.cpu_reset_pulse;

endmodule
